// File: hw/rtl/md5h_pkg.sv
`default_nettype none
package md5h_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned BlkAddrW = $clog2(BlkWords);
  localparam int unsigned RoundW   = 6;
  localparam int unsigned LenW     = 61;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } words_t;

  localparam words_t ChainInit = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  localparam logic [7:0] PadByte = 8'h80;

  // Word index of the final length field within the block
  localparam logic [BlkAddrW-1:0] LenLoIdx = BlkAddrW'(14);
  localparam logic [BlkAddrW-1:0] LenHiIdx = BlkAddrW'(15);
  localparam logic [BlkAddrW-1:0] LastIdx  = BlkAddrW'(BlkWords - 1);

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    StIdle,
    StCmpRd,
    StCmpRnd,
    StCmpAdd,
    StPadFirst,
    StPadFill,
    StFin
  } state_e;

  // Block word used by a given round
  function automatic logic [BlkAddrW-1:0] msg_index(logic [RoundW-1:0] k);
    logic [7:0] kw;
    logic [7:0] p;
    kw = {2'b00, k};
    case (k[5:4])
      2'd0:    p = kw;
      2'd1:    p = kw * 8'd5 + 8'd1;
      2'd2:    p = kw * 8'd3 + 8'd5;
      default: p = kw * 8'd7;
    endcase
    return p[BlkAddrW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/md5h_ram.sv
`default_nettype none
module md5h_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/md5h_round.sv
`default_nettype none
module md5h_round (
  input  wire logic [md5h_pkg::RoundW-1:0] round_i,
  input  wire md5h_pkg::words_t            words_i,
  input  wire logic [md5h_pkg::WordW-1:0]  msg_i,
  output md5h_pkg::words_t                 words_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [4:0]  amt;

  always_comb begin
    unique case (round_i[5:4])
      2'd0:    f = (words_i.b & words_i.c) | (~words_i.b & words_i.d);
      2'd1:    f = (words_i.d & words_i.b) | (~words_i.d & words_i.c);
      2'd2:    f = words_i.b ^ words_i.c ^ words_i.d;
      default: f = words_i.c ^ (words_i.b | ~words_i.d);
    endcase
  end

  assign amt = md5h_pkg::RotAmount[{round_i[5:4], round_i[1:0]}];
  assign sum = words_i.a + f + md5h_pkg::RoundConst[round_i] + msg_i;
  assign dbl = {sum, sum} << amt;

  assign words_o.a = words_i.d;
  assign words_o.b = words_i.b + dbl[63:32];
  assign words_o.c = words_i.b;
  assign words_o.d = words_i.c;

endmodule
`default_nettype wire

// File: hw/rtl/md5_hash_unit.sv
// MD5 digest engine.
// Input channel (in_valid_i/in_ready_o): one word per handshake, up to four
// message bytes with the first byte in bits 7:0, a byte count (values above
// four count as four) and a last flag. Bytes stay packed across partial words.
// Output channel (out_valid_o/out_ready_i): one 16-byte digest per message,
// a0/b0 in digest_first_o and c0/d0 in digest_second_o, little-endian bytes.
// Throughput: one data word per handshake while idle. Every 16th full word
// starts a compression that holds off input: one RAM read lead-in, 64 rounds
// at one per cycle through the block buffer RAM read port, one chain add.
// Last word: padding writes fill the block, and a further block when the
// length field no longer fits; one or two compressions follow, then the
// digest is loaded into the output register.
// A waiting digest does not stop input; only a second finished message waits
// in the finish state until the output register empties.
// Reset: chaining words take the MD5 initial values, counters clear; the
// block buffer RAM is not cleared since every word is written before use.
`default_nettype none
module md5_hash_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      digest_first_o,
  output logic [63:0]      digest_second_o
);

  md5h_pkg::state_e state_q, state_d;
  md5h_pkg::words_t chain_q, chain_d;
  md5h_pkg::words_t words_q, words_d;
  md5h_pkg::words_t round_out;

  logic [md5h_pkg::RoundW-1:0]   rnd_q, rnd_d;
  logic [md5h_pkg::BlkAddrW-1:0] widx_q, widx_d;
  logic [23:0]                   part_q, part_d;
  logic [1:0]                    part_cnt_q, part_cnt_d;
  logic [md5h_pkg::LenW-1:0]     len_q, len_d;
  logic                          last_q, last_d;
  logic                          pad_q, pad_d;
  logic                          final_q, final_d;
  logic                          out_valid_q, out_valid_d;
  logic [63:0]                   dig_first_q, dig_first_d;
  logic [63:0]                   dig_second_q, dig_second_d;

  logic                          accept;
  logic                          fin_go;
  logic [2:0]                    cnt;
  logic [31:0]                   masked;
  logic [55:0]                   merged;
  logic [2:0]                    total;
  logic                          word_full;
  logic                          ram_we;
  logic [md5h_pkg::BlkAddrW-1:0] ram_raddr;
  logic [31:0]                   ram_wdata;
  logic [31:0]                   ram_rdata;
  logic [31:0]                   pad_word;
  logic [31:0]                   fill_word;
  logic [63:0]                   bit_len;

  // Byte merge of the incoming word behind the held partial bytes
  always_comb begin
    cnt = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    for (int i = 0; i < 4; i++) begin
      masked[8*i +: 8] = (3'(i) < cnt) ? data_word_i[8*i +: 8] : 8'h00;
    end
    merged    = {32'h0, part_q} | ({24'h0, masked} << {part_cnt_q, 3'b000});
    total     = {1'b0, part_cnt_q} + cnt;
    word_full = total[2];
  end

  assign bit_len  = {len_q, 3'b000};
  assign pad_word = {8'h00, part_q} | ({24'h0, md5h_pkg::PadByte} << {part_cnt_q, 3'b000});

  always_comb begin
    if (final_q && widx_q == md5h_pkg::LenLoIdx) begin
      fill_word = bit_len[31:0];
    end else if (final_q && widx_q == md5h_pkg::LenHiIdx) begin
      fill_word = bit_len[63:32];
    end else begin
      fill_word = '0;
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign fin_go = (state_q == md5h_pkg::StFin) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      md5h_pkg::StIdle: begin
        if (accept) begin
          if (word_full && widx_q == md5h_pkg::LastIdx) begin
            state_d = md5h_pkg::StCmpRd;
          end else if (last_i) begin
            state_d = md5h_pkg::StPadFirst;
          end
        end
      end
      md5h_pkg::StCmpRd: state_d = md5h_pkg::StCmpRnd;
      md5h_pkg::StCmpRnd: begin
        if (rnd_q == '1) begin
          state_d = md5h_pkg::StCmpAdd;
        end
      end
      md5h_pkg::StCmpAdd: begin
        if (!last_q) begin
          state_d = md5h_pkg::StIdle;
        end else if (!pad_q) begin
          state_d = md5h_pkg::StPadFirst;
        end else if (final_q) begin
          state_d = md5h_pkg::StFin;
        end else begin
          state_d = md5h_pkg::StPadFill;
        end
      end
      md5h_pkg::StPadFirst, md5h_pkg::StPadFill: begin
        if (widx_q == md5h_pkg::LastIdx) begin
          state_d = md5h_pkg::StCmpRd;
        end else begin
          state_d = md5h_pkg::StPadFill;
        end
      end
      md5h_pkg::StFin: begin
        if (fin_go) begin
          state_d = md5h_pkg::StIdle;
        end
      end
      default: state_d = md5h_pkg::StIdle;
    endcase
  end

  // Handshake and RAM control
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = merged[31:0];
    ram_raddr  = md5h_pkg::msg_index('0);
    unique case (state_q)
      md5h_pkg::StIdle: begin
        in_ready_o = 1'b1;
        ram_we     = accept && word_full;
      end
      md5h_pkg::StCmpRnd: begin
        ram_raddr = md5h_pkg::msg_index(rnd_q + 1'b1);
      end
      md5h_pkg::StPadFirst: begin
        ram_we    = 1'b1;
        ram_wdata = pad_word;
      end
      md5h_pkg::StPadFill: begin
        ram_we    = 1'b1;
        ram_wdata = fill_word;
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    chain_d      = chain_q;
    words_d      = words_q;
    rnd_d        = rnd_q;
    widx_d       = widx_q;
    part_d       = part_q;
    part_cnt_d   = part_cnt_q;
    len_d        = len_q;
    last_d       = last_q;
    pad_d        = pad_q;
    final_d      = final_q;
    out_valid_d  = out_valid_q;
    dig_first_d  = dig_first_q;
    dig_second_d = dig_second_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      md5h_pkg::StIdle: begin
        if (accept) begin
          len_d  = len_q + md5h_pkg::LenW'(cnt);
          last_d = last_i;
          if (word_full) begin
            widx_d     = widx_q + 1'b1;
            part_d     = merged[55:32];
            part_cnt_d = total[1:0];
          end else begin
            part_d     = merged[23:0];
            part_cnt_d = total[1:0];
          end
        end
      end
      md5h_pkg::StCmpRd: begin
        words_d = chain_q;
        rnd_d   = '0;
      end
      md5h_pkg::StCmpRnd: begin
        words_d = round_out;
        rnd_d   = rnd_q + 1'b1;
      end
      md5h_pkg::StCmpAdd: begin
        chain_d.a = chain_q.a + words_q.a;
        chain_d.b = chain_q.b + words_q.b;
        chain_d.c = chain_q.c + words_q.c;
        chain_d.d = chain_q.d + words_q.d;
        // Padding spilled past the block: the length goes in the next one
        if (pad_q) begin
          final_d = 1'b1;
        end
      end
      md5h_pkg::StPadFirst: begin
        pad_d      = 1'b1;
        final_d    = (widx_q < md5h_pkg::LenLoIdx);
        widx_d     = widx_q + 1'b1;
        part_d     = '0;
        part_cnt_d = '0;
      end
      md5h_pkg::StPadFill: begin
        widx_d = widx_q + 1'b1;
      end
      md5h_pkg::StFin: begin
        if (fin_go) begin
          out_valid_d  = 1'b1;
          dig_first_d  = {chain_q.b, chain_q.a};
          dig_second_d = {chain_q.d, chain_q.c};
          chain_d      = md5h_pkg::ChainInit;
          widx_d       = '0;
          len_d        = '0;
          last_d       = 1'b0;
          pad_d        = 1'b0;
          final_d      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5h_pkg::StIdle;
      chain_q     <= md5h_pkg::ChainInit;
      rnd_q       <= '0;
      widx_q      <= '0;
      part_q      <= '0;
      part_cnt_q  <= '0;
      len_q       <= '0;
      last_q      <= 1'b0;
      pad_q       <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      rnd_q       <= rnd_d;
      widx_q      <= widx_d;
      part_q      <= part_d;
      part_cnt_q  <= part_cnt_d;
      len_q       <= len_d;
      last_q      <= last_d;
      pad_q       <= pad_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q      <= words_d;
    dig_first_q  <= dig_first_d;
    dig_second_q <= dig_second_d;
  end

  md5h_ram #(
    .Width(md5h_pkg::WordW),
    .Depth(md5h_pkg::BlkWords)
  ) u_blk_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  md5h_round u_round (
    .round_i(rnd_q),
    .words_i(words_q),
    .msg_i  (ram_rdata),
    .words_o(round_out)
  );

  assign out_valid_o     = out_valid_q;
  assign digest_first_o  = dig_first_q;
  assign digest_second_o = dig_second_q;

  a_no_write_in_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5h_pkg::StCmpRnd || state_q == md5h_pkg::StCmpRd) |-> !ram_we)
    else $error("block buffer written during compression");

  a_rounds_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5h_pkg::StCmpRd) |=> (state_q == md5h_pkg::StCmpRnd && rnd_q == '0))
    else $error("rounds did not start at round zero");

  a_digest_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == md5h_pkg::StFin))
    else $error("digest loaded outside finish");

  a_chain_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (chain_q == md5h_pkg::ChainInit && len_q == '0 && widx_q == '0))
    else $error("state not restarted after digest");

  a_idle_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5h_pkg::StCmpAdd && !last_q) |=> (state_q == md5h_pkg::StIdle && widx_q == '0))
    else $error("block index not wrapped after data block");

endmodule
`default_nettype wire
